// ===== src/vfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_pkg
// Types, constants and the quarter-wave sine table of the V/f ramp voltage
// vector generator.
// ----------------------------------------------------------------------------
package vfr_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam longint MOD_GAIN_Q24 = 64'sd19372816;

    localparam int     TBL_N  = 1 << SINE_TABLE_BITS;
    localparam int     Q4     = TBL_N / 4;
    localparam int     QIDX_W = SINE_TABLE_BITS - 1;
    localparam longint ONE_Q  = 64'sd1 <<< FRAC_BITS;
    localparam longint PI_Q32 = 64'sd13493037705;

    localparam longint GAIN_Q64 = (MOD_GAIN_Q24 <<< FRAC_BITS) >>> 24;
    localparam longint INV_RAW  = (64'sd1 <<< (2 * FRAC_BITS)) / GAIN_Q64;
    localparam longint INV_SAT  = (INV_RAW > 64'sd2147483647) ? 64'sd2147483647 : INV_RAW;

    localparam logic signed [31:0] GAIN_Q   = 32'(GAIN_Q64);
    localparam logic signed [31:0] INV_GAIN = 32'(INV_SAT);
    localparam logic signed [31:0] DUTY_MAX = 32'((64'sd98 * ONE_Q) / 64'sd100);
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

    localparam int DIV_W = FRAC_BITS + 32;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_AW  = 5;
    localparam int PHASE_W = 24;

    typedef enum logic [2:0] {
        REG_FREQ_TARGET = 3'd0,
        REG_RAMP_TIME   = 3'd1,
        REG_VOLT_LOW    = 3'd2,
        REG_VOLT_HIGH   = 3'd3,
        REG_FREQ_LOW    = 3'd4,
        REG_FREQ_HIGH   = 3'd5,
        REG_TICK_PERIOD = 3'd6,
        REG_BUS_VOLTAGE = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_OTHER   = 2'd0,
        MODE_READY   = 2'd1,
        MODE_RUNNING = 2'd2
    } run_mode_t;

    typedef enum logic [4:0] {
        STEP_DIV_FT,
        STEP_MUL_FN,
        STEP_DIV_SL,
        STEP_MUL_VR,
        STEP_MUL_PS,
        STEP_HOLD,
        STEP_READY,
        STEP_MUL_G,
        STEP_DIV_D,
        STEP_MUL_U1,
        STEP_MUL_U2,
        STEP_PHASE,
        STEP_SIN,
        STEP_COS,
        STEP_MUL_A,
        STEP_MUL_B
    } step_t;

    typedef enum logic [1:0] {
        UNIT_NONE,
        UNIT_MUL,
        UNIT_DIV
    } unit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [30:0] freq_target;
        logic [30:0] ramp_time;
        logic [30:0] volt_low;
        logic [30:0] volt_high;
        logic [30:0] freq_low;
        logic [30:0] freq_high;
        logic [30:0] tick_period;
        logic [30:0] bus_voltage;
    } cfg_t;

    typedef struct packed {
        logic  start;
        step_t step;
        logic  load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic ramp_active;
    } dp_sts_t;

    typedef struct packed {
        logic signed [31:0]   volt_alpha;
        logic signed [31:0]   volt_beta;
        logic signed [31:0]   volt_out;
        logic signed [31:0]   freq_out;
        logic [PHASE_W-1:0]   phase;
        logic                 period_wrap;
    } out_pay_t;

    typedef logic signed [31:0] qtab_t [0:Q4];

    function automatic unit_t step_unit(input step_t s);
        unit_t u;
        case (s)
            STEP_DIV_FT, STEP_DIV_SL, STEP_DIV_D: u = UNIT_DIV;
            STEP_MUL_FN, STEP_MUL_VR, STEP_MUL_PS, STEP_MUL_G,
            STEP_MUL_U1, STEP_MUL_U2, STEP_MUL_A, STEP_MUL_B: u = UNIT_MUL;
            default: u = UNIT_NONE;
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -65'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic longint taylor_div(input longint v, input int n);
        longint r;
        case (n)
            1:       r = v / 64'sd6;
            2:       r = v / 64'sd20;
            3:       r = v / 64'sd42;
            4:       r = v / 64'sd72;
            5:       r = v / 64'sd110;
            default: r = v / 64'sd156;
        endcase
        return r;
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t  t;
        longint x;
        longint x2;
        longint term;
        longint sum;
        int     sh;
        for (int j = 0; j <= Q4; j++) begin
            x    = (PI_Q32 * longint'(j)) >>> (SINE_TABLE_BITS + 1);
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++) begin
                term = taylor_div((term * x2) >>> 30, n);
                sum  = ((n & 1) == 1) ? sum - term : sum + term;
            end
            if (sum < 0) begin
                sum = 0;
            end
            sh = 30 - FRAC_BITS;
            if (sh > 0) begin
                sum = (sum + (64'sd1 <<< (sh - 1))) >>> sh;
            end
            if (sum > ONE_Q) begin
                sum = ONE_Q;
            end
            t[j] = sum[31:0];
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    function automatic logic signed [31:0] sine_at(input logic [SINE_TABLE_BITS-1:0] k);
        logic [1:0]        quad;
        logic [QIDX_W-1:0] r;
        logic [QIDX_W-1:0] ri;
        logic signed [31:0] v;
        quad = k[SINE_TABLE_BITS-1 -: 2];
        r    = {1'b0, k[SINE_TABLE_BITS-3:0]};
        ri   = QIDX_W'(Q4) - r;
        case (quad)
            2'd0:    v = QTAB[r];
            2'd1:    v = QTAB[ri];
            2'd2:    v = -QTAB[r];
            default: v = -QTAB[ri];
        endcase
        return v;
    endfunction

endpackage

// ===== src/vfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_in_if / vfr_out_if
// Valid/ready channels for tick requests and voltage vector results.
// ----------------------------------------------------------------------------
interface vfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] run_mode;

    modport source (output valid, output run_mode, input ready);
    modport sink   (input valid, input run_mode, output ready);
endinterface

interface vfr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] volt_alpha;
    logic signed [31:0] volt_beta;
    logic signed [31:0] volt_out;
    logic signed [31:0] freq_out;
    logic [23:0]        phase;
    logic               period_wrap;

    modport source (output valid, output volt_alpha, output volt_beta, output volt_out,
                    output freq_out, output phase, output period_wrap, input ready);
    modport sink   (input valid, input volt_alpha, input volt_beta, input volt_out,
                    input freq_out, input phase, input period_wrap, output ready);
endinterface

// ===== src/vfr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_dp
// Datapath: ramp and vector state, shared Q multiplier, bit-serial divider,
// sine table lookup and result register.
// ----------------------------------------------------------------------------
module vfr_dp
    import vfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  dp_cmd_t  cmd,
    output dp_sts_t  sts,
    output out_pay_t pay
);

    logic signed [31:0]    timer_reg, freq_reg, vref_reg, pstep_reg;
    logic [FRAC_BITS-1:0]  pacc_reg;
    logic signed [31:0]    t0_reg, duty_reg, uout_reg, alpha_reg, beta_reg, sn_reg, cs_reg;
    logic                  wrap_reg;
    out_pay_t              pay_reg;

    step_t                 stepq_reg;
    logic                  pend_reg;
    logic signed [63:0]    prod_reg;
    logic [DIV_W-1:0]      num_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  dneg_reg, dzero_reg, aneg_reg;

    logic signed [31:0]    op_a, op_b;
    logic signed [31:0]    fn_minus_fl;
    logic signed [63:0]    prod_sh;
    logic signed [31:0]    mul_res, div_res, unit_res;
    logic signed [56:0]    sq;
    logic [32:0]           rem_sh;
    logic                  ge;
    logic                  wb;
    logic [31:0]           mag_a, mag_b;
    logic signed [32:0]    acc;
    logic [SINE_TABLE_BITS-1:0] idx;

    assign fn_minus_fl = sat32(65'(freq_reg) - 65'(signed'({1'b0, cfg.freq_low})));

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.step)
            STEP_DIV_FT: begin op_a = {1'b0, cfg.freq_target}; op_b = {1'b0, cfg.ramp_time}; end
            STEP_MUL_FN: begin op_a = t0_reg;   op_b = timer_reg; end
            STEP_DIV_SL:
            begin
                op_a = 32'(33'({1'b0, cfg.volt_high}) - 33'({1'b0, cfg.volt_low}));
                op_b = 32'(33'({1'b0, cfg.freq_high}) - 33'({1'b0, cfg.freq_low}));
            end
            STEP_MUL_VR: begin op_a = t0_reg;   op_b = fn_minus_fl; end
            STEP_MUL_PS: begin op_a = freq_reg; op_b = {1'b0, cfg.tick_period}; end
            STEP_MUL_G:  begin op_a = vref_reg; op_b = GAIN_Q; end
            STEP_DIV_D:  begin op_a = t0_reg;   op_b = {1'b0, cfg.bus_voltage}; end
            STEP_MUL_U1: begin op_a = {1'b0, cfg.bus_voltage}; op_b = duty_reg; end
            STEP_MUL_U2: begin op_a = t0_reg;   op_b = INV_GAIN; end
            STEP_MUL_A:  begin op_a = duty_reg; op_b = cs_reg; end
            STEP_MUL_B:  begin op_a = duty_reg; op_b = sn_reg; end
            default:     begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mag_a  = op_a[31] ? 32'(-op_a) : op_a;
    assign mag_b  = op_b[31] ? 32'(-op_b) : op_b;

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign mul_res = sat32({prod_sh[63], prod_sh});

    assign sq      = dneg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign div_res = dzero_reg ? (aneg_reg ? S32_MIN : S32_MAX)
                               : sat32({{8{sq[56]}}, sq});

    assign unit_res = (step_unit(stepq_reg) == UNIT_DIV) ? div_res : mul_res;

    assign rem_sh = {rem_reg, num_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    assign wb = pend_reg && ((step_unit(stepq_reg) != UNIT_DIV) ||
                             (cnt_reg == CNT_W'(DIV_W)));

    assign acc = $signed({9'd0, pacc_reg}) + $signed({pstep_reg[31], pstep_reg});
    assign idx = pacc_reg[FRAC_BITS-1 -: SINE_TABLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg  <= 1'b0;
            stepq_reg <= STEP_MUL_G;
            cnt_reg   <= '0;
        end else begin
            if (cmd.start) begin
                pend_reg  <= 1'b1;
                stepq_reg <= cmd.step;
                cnt_reg   <= '0;
            end else begin
                if (wb) begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg && step_unit(stepq_reg) == UNIT_DIV &&
                    cnt_reg != CNT_W'(DIV_W)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            prod_reg  <= op_a * op_b;
            num_reg   <= {mag_a, FRAC_BITS'(0)};
            rem_reg   <= '0;
            den_reg   <= mag_b;
            dneg_reg  <= op_a[31] ^ op_b[31];
            dzero_reg <= (op_b == '0);
            aneg_reg  <= op_a[31];
        end else if (pend_reg && step_unit(stepq_reg) == UNIT_DIV &&
                     cnt_reg != CNT_W'(DIV_W)) begin
            rem_reg <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            num_reg <= {num_reg[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timer_reg <= '0;
            freq_reg  <= '0;
            vref_reg  <= '0;
            pstep_reg <= '0;
            pacc_reg  <= '0;
        end else if (wb) begin
            case (stepq_reg)
                STEP_MUL_FN:
                begin
                    freq_reg  <= unit_res;
                    timer_reg <= sat32(65'(timer_reg) + 65'(signed'({1'b0, cfg.tick_period})));
                end
                STEP_MUL_VR: vref_reg  <= sat32(65'(signed'({1'b0, cfg.volt_low})) + 65'(unit_res));
                STEP_MUL_PS: pstep_reg <= unit_res;
                STEP_HOLD:
                begin
                    freq_reg <= {1'b0, cfg.freq_high};
                    vref_reg <= {1'b0, cfg.volt_high};
                end
                STEP_READY:
                begin
                    timer_reg <= '0;
                    freq_reg  <= {1'b0, cfg.freq_low};
                    vref_reg  <= {1'b0, cfg.volt_low};
                end
                STEP_PHASE:  pacc_reg <= acc[FRAC_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb) begin
            case (stepq_reg)
                STEP_DIV_FT, STEP_DIV_SL, STEP_MUL_G, STEP_MUL_U1: t0_reg <= unit_res;
                STEP_DIV_D:  duty_reg  <= (unit_res > DUTY_MAX) ? DUTY_MAX : unit_res;
                STEP_MUL_U2: uout_reg  <= unit_res;
                STEP_PHASE:  wrap_reg  <= |acc[32:FRAC_BITS];
                STEP_SIN:    sn_reg    <= sine_at(idx);
                STEP_COS:    cs_reg    <= sine_at(idx + SINE_TABLE_BITS'(Q4));
                STEP_MUL_A:  alpha_reg <= unit_res;
                STEP_MUL_B:  beta_reg  <= unit_res;
                default:     ;
            endcase
        end
        if (cmd.load_out) begin
            pay_reg.volt_alpha  <= alpha_reg;
            pay_reg.volt_beta   <= beta_reg;
            pay_reg.volt_out    <= uout_reg;
            pay_reg.freq_out    <= freq_reg;
            pay_reg.phase       <= PHASE_W'(pacc_reg);
            pay_reg.period_wrap <= wrap_reg;
        end
    end

    assign sts.done        = wb;
    assign sts.ramp_active = timer_reg < $signed({1'b0, cfg.ramp_time});
    assign pay             = pay_reg;

endmodule

// ===== src/vfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_ctrl
// Sequencer: accepts a tick, walks the ramp and vector steps on the datapath,
// and hands the finished transaction to the output register.
// ----------------------------------------------------------------------------
module vfr_ctrl
    import vfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic        ovalid_reg, ovalid_next;
    logic        slot_free;

    assign slot_free = !ovalid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            step_reg   <= STEP_MUL_G;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = step_reg;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = ST_ISSUE;
                    case (in_mode)
                        MODE_RUNNING: step_next = sts.ramp_active ? STEP_DIV_FT : STEP_HOLD;
                        MODE_READY:   step_next = STEP_READY;
                        default:      step_next = STEP_MUL_G;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.done) begin
                    if (step_reg == STEP_MUL_B) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_ISSUE;
                        case (step_reg)
                            STEP_DIV_FT: step_next = STEP_MUL_FN;
                            STEP_MUL_FN: step_next = STEP_DIV_SL;
                            STEP_DIV_SL: step_next = STEP_MUL_VR;
                            STEP_MUL_VR: step_next = STEP_MUL_PS;
                            STEP_MUL_G:  step_next = STEP_DIV_D;
                            STEP_DIV_D:  step_next = STEP_MUL_U1;
                            STEP_MUL_U1: step_next = STEP_MUL_U2;
                            STEP_MUL_U2: step_next = STEP_PHASE;
                            STEP_PHASE:  step_next = STEP_SIN;
                            STEP_SIN:    step_next = STEP_COS;
                            STEP_COS:    step_next = STEP_MUL_A;
                            STEP_MUL_A:  step_next = STEP_MUL_B;
                            default:     step_next = STEP_MUL_G;
                        endcase
                    end
                end
            end
            ST_OUT:
            begin
                if (slot_free) begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ovalid_reg;

endmodule

// ===== src/vf_ramp_voltage_vector_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vf_ramp_voltage_vector_generator_unit
// Scalar V/f frequency ramp and alpha/beta voltage vector generator, one
// transaction per PWM tick.
//
//   channel   direction  handshake        payload
//   in_ch     in         valid/ready      run_mode
//   out_ch    out        valid/ready      volt_alpha, volt_beta, volt_out,
//                                         freq_out, phase, period_wrap
//   apb       in         psel/penable     eight 31-bit registers at 4*i
//
// A tick walks the vector steps, after the ramp steps while the ramp is
// active or after the ready or hold step; each Q divide runs on the one
// bit-serial divider (56 quotient bits plus issue and write-back). One tick
// is in flight at a time; a new tick is accepted while the previous result
// waits on out_ch. A stall on out_ch holds the last step until the result
// register frees.
// Reset clears the ramp and phase state and loads the register defaults.
// ----------------------------------------------------------------------------
module vf_ramp_voltage_vector_generator_unit
    import vfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    vfr_in_if.sink            in_ch,
    vfr_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_sts_t  sts;
    out_pay_t pay;
    reg_idx_t ridx;

    assign ridx   = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.freq_target <= 31'd0;
            cfg_reg.ramp_time   <= 31'd16777216;
            cfg_reg.volt_low    <= 31'd0;
            cfg_reg.volt_high   <= 31'd16777216;
            cfg_reg.freq_low    <= 31'd0;
            cfg_reg.freq_high   <= 31'd16777216;
            cfg_reg.tick_period <= 31'd16777;
            cfg_reg.bus_voltage <= 31'd335544320;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_FREQ_TARGET: cfg_reg.freq_target <= pwdata[30:0];
                REG_RAMP_TIME:   cfg_reg.ramp_time   <= pwdata[30:0];
                REG_VOLT_LOW:    cfg_reg.volt_low    <= pwdata[30:0];
                REG_VOLT_HIGH:   cfg_reg.volt_high   <= pwdata[30:0];
                REG_FREQ_LOW:    cfg_reg.freq_low    <= pwdata[30:0];
                REG_FREQ_HIGH:   cfg_reg.freq_high   <= pwdata[30:0];
                REG_TICK_PERIOD: cfg_reg.tick_period <= pwdata[30:0];
                REG_BUS_VOLTAGE: cfg_reg.bus_voltage <= pwdata[30:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_FREQ_TARGET: prdata = {1'b0, cfg_reg.freq_target};
            REG_RAMP_TIME:   prdata = {1'b0, cfg_reg.ramp_time};
            REG_VOLT_LOW:    prdata = {1'b0, cfg_reg.volt_low};
            REG_VOLT_HIGH:   prdata = {1'b0, cfg_reg.volt_high};
            REG_FREQ_LOW:    prdata = {1'b0, cfg_reg.freq_low};
            REG_FREQ_HIGH:   prdata = {1'b0, cfg_reg.freq_high};
            REG_TICK_PERIOD: prdata = {1'b0, cfg_reg.tick_period};
            REG_BUS_VOLTAGE: prdata = {1'b0, cfg_reg.bus_voltage};
            default:         prdata = '0;
        endcase
    end

    vfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_mode   (in_ch.run_mode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    vfr_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .sts   (sts),
        .pay   (pay)
    );

    assign out_ch.volt_alpha  = pay.volt_alpha;
    assign out_ch.volt_beta   = pay.volt_beta;
    assign out_ch.volt_out    = pay.volt_out;
    assign out_ch.freq_out    = pay.freq_out;
    assign out_ch.phase       = pay.phase;
    assign out_ch.period_wrap = pay.period_wrap;

endmodule

// ===== verif/vfr_tick_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfr_tick_checker
// Watches the tick and result channels of the V/f voltage vector generator,
// computes the expected vector for every accepted tick from its own copy of
// the ramp state and registers, and compares each result field by field.
// ----------------------------------------------------------------------------
module vfr_tick_checker
    import vfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    vfr_in_if.sink            in_mon,
    vfr_out_if.sink           out_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    typedef logic signed [31:0] s32_t;

    s32_t     regs [0:7];
    s32_t     timer_q, acc_q, step_q, freq_q, vref_q;
    s32_t     sin_tab [0:TBL_N-1];
    out_pay_t vector_queue [$];

    function automatic s32_t clip32(input longint v);
        s32_t r;
        if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'sh8000_0000;
        else r = s32_t'(v);
        return r;
    endfunction

    function automatic s32_t fx_mul(input s32_t a, input s32_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip32(p >>> FRAC_BITS);
    endfunction

    function automatic s32_t fx_div(input s32_t a, input s32_t b);
        s32_t r;
        if (b == 0) r = (a >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else r = clip32((longint'(a) * ONE_Q) / longint'(b));
        return r;
    endfunction

    function automatic longint quarter_wave(input int j);
        longint x, x2, term, total;
        x = (PI_Q32 * longint'(j)) / longint'(2 * TBL_N);
        x2 = (x * x) >>> 30;
        term = x;
        total = x;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
            total = (n % 2 == 1) ? total - term : total + term;
        end
        if (total < 0) total = 0;
        total = (total + (64'sd1 <<< (30 - FRAC_BITS - 1))) >>> (30 - FRAC_BITS);
        if (total > ONE_Q) total = ONE_Q;
        return total;
    endfunction

    task automatic load_defaults();
        int q, r;
        regs[REG_FREQ_TARGET] = 0;
        regs[REG_RAMP_TIME]   = 16777216;
        regs[REG_VOLT_LOW]    = 0;
        regs[REG_VOLT_HIGH]   = 16777216;
        regs[REG_FREQ_LOW]    = 0;
        regs[REG_FREQ_HIGH]   = 16777216;
        regs[REG_TICK_PERIOD] = 16777;
        regs[REG_BUS_VOLTAGE] = 335544320;
        timer_q = 0; acc_q = 0; step_q = 0; freq_q = 0; vref_q = 0;
        for (int k = 0; k < TBL_N; k++) begin
            q = k / Q4;
            r = k % Q4;
            case (q)
                0: sin_tab[k] = s32_t'(quarter_wave(r));
                1: sin_tab[k] = s32_t'(quarter_wave(Q4 - r));
                2: sin_tab[k] = -s32_t'(quarter_wave(r));
                default: sin_tab[k] = -s32_t'(quarter_wave(Q4 - r));
            endcase
        end
    endtask

    task automatic predict_vector(input logic [1:0] mode);
        s32_t slope, duty, uout, sn, cs;
        longint acc;
        int idx;
        out_pay_t v;
        if (mode == MODE_RUNNING) begin
            if (timer_q < regs[REG_RAMP_TIME]) begin
                freq_q = fx_mul(fx_div(regs[REG_FREQ_TARGET], regs[REG_RAMP_TIME]), timer_q);
                timer_q = clip32(longint'(timer_q) + regs[REG_TICK_PERIOD]);
                slope = fx_div(clip32(longint'(regs[REG_VOLT_HIGH]) - regs[REG_VOLT_LOW]),
                               clip32(longint'(regs[REG_FREQ_HIGH]) - regs[REG_FREQ_LOW]));
                vref_q = clip32(longint'(regs[REG_VOLT_LOW]) +
                                fx_mul(slope, clip32(longint'(freq_q) - regs[REG_FREQ_LOW])));
                step_q = fx_mul(freq_q, regs[REG_TICK_PERIOD]);
            end else begin
                freq_q = regs[REG_FREQ_HIGH];
                vref_q = regs[REG_VOLT_HIGH];
            end
        end else if (mode == MODE_READY) begin
            timer_q = 0;
            freq_q = regs[REG_FREQ_LOW];
            vref_q = regs[REG_VOLT_LOW];
        end
        duty = fx_div(fx_mul(vref_q, GAIN_Q), regs[REG_BUS_VOLTAGE]);
        if (duty > DUTY_MAX) duty = DUTY_MAX;
        uout = fx_mul(fx_mul(regs[REG_BUS_VOLTAGE], duty), INV_GAIN);
        acc = longint'(acc_q) + longint'(step_q);
        v.period_wrap = (acc >= ONE_Q) || (acc < 0);
        acc_q = s32_t'(acc & (ONE_Q - 1));
        idx = (acc_q >>> (FRAC_BITS - SINE_TABLE_BITS)) & (TBL_N - 1);
        sn = sin_tab[idx];
        cs = sin_tab[(idx + Q4) & (TBL_N - 1)];
        v.volt_alpha = fx_mul(duty, cs);
        v.volt_beta = fx_mul(duty, sn);
        v.volt_out = uout;
        v.freq_out = freq_q;
        v.phase = acc_q[23:0];
        vector_queue.push_back(v);
    endtask

    task automatic compare_vector();
        out_pay_t e;
        if (vector_queue.size() == 0) begin
            $error("result with no tick pending");
            fail_count++;
            return;
        end
        e = vector_queue.pop_front();
        if (out_mon.volt_alpha !== e.volt_alpha) begin
            $error("volt_alpha exp %0d got %0d", e.volt_alpha, out_mon.volt_alpha);
            fail_count++;
        end
        if (out_mon.volt_beta !== e.volt_beta) begin
            $error("volt_beta exp %0d got %0d", e.volt_beta, out_mon.volt_beta);
            fail_count++;
        end
        if (out_mon.volt_out !== e.volt_out) begin
            $error("volt_out exp %0d got %0d", e.volt_out, out_mon.volt_out);
            fail_count++;
        end
        if (out_mon.freq_out !== e.freq_out) begin
            $error("freq_out exp %0d got %0d", e.freq_out, out_mon.freq_out);
            fail_count++;
        end
        if (out_mon.phase !== e.phase) begin
            $error("phase exp %0d got %0d", e.phase, out_mon.phase);
            fail_count++;
        end
        if (out_mon.period_wrap !== e.period_wrap) begin
            $error("period_wrap exp %0d got %0d", e.period_wrap, out_mon.period_wrap);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        load_defaults();
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (psel && penable && pwrite && pready && paddr[4:2] <= 3'd7 && paddr[1:0] == 2'b00)
                regs[paddr[4:2]] = s32_t'({1'b0, pwdata[30:0]});
            if (out_mon.valid && out_mon.ready)
                compare_vector();
            if (in_mon.valid && in_mon.ready)
                predict_vector(in_mon.run_mode);
            pending = vector_queue.size();
        end
    end

endmodule

// ===== verif/tb_vf_ramp_voltage_vector_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vf_ramp_voltage_vector_generator_unit
// Drives tick transactions in several register settings, with random gaps and
// result back-pressure, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_vf_ramp_voltage_vector_generator_unit;
    import vfr_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    logic              hold_off;
    logic              driving;

    vfr_in_if  in_ch ();
    vfr_out_if out_ch ();

    vf_ramp_voltage_vector_generator_unit dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    vfr_tick_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("vf_ramp_voltage_vector_generator_unit: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    initial
    begin
        int n;
        out_ch.ready = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ch.ready <= 0;
            end else if (driving) begin
                out_ch.ready <= 1;
            end else begin
                n = gap_len();
                if (n == 0) begin
                    out_ch.ready <= 1;
                end else begin
                    out_ch.ready <= 0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic reg_write(input reg_idx_t r, input logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= CFG_AW'({r, 2'b00}); pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_tick(input logic [1:0] mode, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            @(negedge clk);
            in_ch.valid <= 0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1;
        in_ch.run_mode <= mode;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic run_phase(input int count);
        int r;
        send_tick(MODE_READY, 1);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) send_tick(MODE_RUNNING, 1);
            else if (r < 90) send_tick(MODE_READY, 1);
            else send_tick(2'($urandom_range(0, 3)), 1);
        end
        settle();
    endtask

    task automatic random_regs();
        reg_write(REG_FREQ_TARGET, $urandom_range(0, 32'h0200_0000));
        reg_write(REG_RAMP_TIME, $urandom_range(0, 32'h0040_0000));
        reg_write(REG_VOLT_LOW, $urandom_range(0, 32'h0100_0000));
        reg_write(REG_VOLT_HIGH, $urandom_range(0, 32'h1000_0000));
        reg_write(REG_FREQ_LOW, $urandom_range(0, 32'h0080_0000));
        reg_write(REG_FREQ_HIGH, $urandom_range(0, 32'h0200_0000));
        reg_write(REG_TICK_PERIOD, $urandom_range(0, 32'h0010_0000));
        reg_write(REG_BUS_VOLTAGE, $urandom_range(1, 32'h2000_0000));
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_ch.valid = 0; in_ch.run_mode = MODE_OTHER;
        hold_off = 0; driving = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (5) @(negedge clk);

        // directed: every mode with reset registers, including mode three
        send_tick(MODE_OTHER, 0);
        send_tick(MODE_READY, 0);
        repeat (4) send_tick(MODE_RUNNING, 0);
        send_tick(2'd3, 0);
        send_tick(MODE_RUNNING, 0);
        settle();

        // extremes: zero ramp time, division by zero, saturation, duty clamp
        reg_write(REG_RAMP_TIME, 0);
        reg_write(REG_FREQ_HIGH, 32'h7FFF_FFFF);
        reg_write(REG_VOLT_HIGH, 32'h7FFF_FFFF);
        reg_write(REG_BUS_VOLTAGE, 1);
        send_tick(MODE_READY, 0);
        send_tick(MODE_RUNNING, 0);
        send_tick(MODE_RUNNING, 0);
        settle();
        reg_write(REG_FREQ_TARGET, 32'h7FFF_FFFF);
        reg_write(REG_RAMP_TIME, 32'h7FFF_FFFF);
        reg_write(REG_TICK_PERIOD, 32'h7FFF_FFFF);
        reg_write(REG_FREQ_LOW, 32'h7FFF_FFFF);
        reg_write(REG_VOLT_LOW, 32'h7FFF_FFFF);
        reg_write(REG_BUS_VOLTAGE, 32'h7FFF_FFFF);
        send_tick(MODE_READY, 0);
        repeat (4) send_tick(MODE_RUNNING, 0);
        settle();
        reg_write(REG_FREQ_HIGH, 0);
        reg_write(REG_VOLT_LOW, 0);
        reg_write(REG_FREQ_LOW, 0);
        reg_write(REG_TICK_PERIOD, 32'h0000_4000);
        reg_write(REG_RAMP_TIME, 32'h0002_0000);
        reg_write(REG_FREQ_TARGET, 32'h0100_0000);
        send_tick(MODE_READY, 0);
        repeat (4) send_tick(MODE_RUNNING, 0);
        settle();

        // back-pressure: hold results while ticks keep arriving
        hold_off = 1;
        fork
            repeat (6) send_tick(MODE_RUNNING, 0);
            begin
                repeat (2000) @(posedge clk);
                hold_off = 0;
            end
        join
        settle();

        for (int p = 0; p < 10; p++) begin
            random_regs();
            run_phase(78);
        end

        settle();
        if (fail_count == 0)
            $display("vf_ramp_voltage_vector_generator_unit: match");
        else
            $display("vf_ramp_voltage_vector_generator_unit: mismatch");
        $finish;
    end

endmodule
